>>> rtl/nsf_pkg.sv
// ----------------------------------------------------------------------------
// nsf_pkg
// Shared types, character codes and helpers of the sentence framer.
// ----------------------------------------------------------------------------
package nsf_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned APB_W    = 32;
  localparam int unsigned PADDR_W  = 3;

  localparam logic [PADDR_W-1:0] REG_MAX_LINE_ADDR = 3'd0;
  localparam logic [CFG_W-1:0]   MAX_LINE_RESET    = 7'd64;

  // Character codes that steer the framer.
  localparam logic [BYTE_W-1:0] CHAR_NUL    = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CHAR_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CHAR_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_DEL    = 8'h7F;

  // Dollar, star and two digits: anything longer holds at least one payload byte
  // once the second digit is stored.
  localparam int unsigned MIN_FILL = 4;

  typedef enum logic [1:0] {
    PH_WAIT_START,
    PH_PAYLOAD,
    PH_DIGIT1,
    PH_DIGIT2
  } framer_phase_e;

  // Control that the framer hands to every storage cell.
  typedef struct packed {
    logic              load;
    logic              shift;
    logic [BYTE_W-1:0] data;
  } cell_ctrl_t;

  // Bit 4 set means the byte is not a hex digit; bits 3:0 hold its value.
  function automatic logic [4:0] hex_value(input logic [BYTE_W-1:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b0, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h57)};
    end
    return v;
  endfunction

endpackage

>>> rtl/nsf_cell.sv
// ----------------------------------------------------------------------------
// nsf_cell
// One byte of the line buffer: loads at its own index, shifts toward the head.
// ----------------------------------------------------------------------------
module nsf_cell #(
  parameter int unsigned IDX_W    = 6,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                              clk_i,
  input  nsf_pkg::cell_ctrl_t               ctrl_i,
  input  logic [IDX_W-1:0]                  wr_idx_i,
  input  logic [nsf_pkg::BYTE_W-1:0]        next_data_i,
  output logic [nsf_pkg::BYTE_W-1:0]        data_o
);
  import nsf_pkg::*;

  logic [BYTE_W-1:0] data_q, data_d;
  logic              hit;

  assign hit = ctrl_i.load && (wr_idx_i == IDX_W'(CELL_IDX));

  always_comb begin
    data_d = data_q;
    if (hit) begin
      data_d = ctrl_i.data;
    end else if (ctrl_i.shift) begin
      data_d = next_data_i;
    end
  end

  // Payload only; contents are defined by the writes that precede any read.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

>>> rtl/nsf_ctrl.sv
// ----------------------------------------------------------------------------
// nsf_ctrl
// Framer state machine, running checksum and drain counter of the line buffer.
// ----------------------------------------------------------------------------
module nsf_ctrl #(
  parameter int unsigned LINE_BUFFER_DEPTH = 64,
  parameter int unsigned CW = $clog2(LINE_BUFFER_DEPTH + 1),
  parameter int unsigned IW = $clog2(LINE_BUFFER_DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [nsf_pkg::BYTE_W-1:0]  rx_byte_i,
  input  logic [nsf_pkg::CFG_W-1:0]   max_line_length_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        last_of_line_o,
  output nsf_pkg::cell_ctrl_t         cell_ctrl_o,
  output logic [IW-1:0]               wr_idx_o
);
  import nsf_pkg::*;

  localparam logic [CFG_W-1:0] DEPTH_CFG = CFG_W'(LINE_BUFFER_DEPTH);

  framer_phase_e     phase_q, phase_d;
  logic [CW-1:0]     fill_q, fill_d;
  logic [CW-1:0]     remain_q, remain_d;
  logic [BYTE_W-1:0] xor_q, xor_d;
  logic [BYTE_W-1:0] digit_hi_q, digit_hi_d;

  logic              in_fire, out_fire;
  logic              is_nul, is_dollar, is_star, is_bad;
  logic [CFG_W-1:0]  cap;
  logic [4:0]        hi_val, lo_val;
  logic              sum_ok;

  assign in_ready_o  = (remain_q == '0);
  assign out_valid_o = (remain_q != '0);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  // Classify the incoming byte.
  always_comb begin
    cap       = (max_line_length_i > DEPTH_CFG) ? DEPTH_CFG : max_line_length_i;
    is_nul    = (rx_byte_i == CHAR_NUL);
    is_dollar = (rx_byte_i == CHAR_DOLLAR);
    is_star   = (rx_byte_i == CHAR_STAR);
    is_bad    = (CFG_W'(fill_q) >= cap) || (rx_byte_i <= CHAR_SPACE)
                || (rx_byte_i == CHAR_DEL);
    hi_val    = hex_value(digit_hi_q);
    lo_val    = hex_value(rx_byte_i);
    sum_ok    = !hi_val[4] && !lo_val[4] && ({hi_val[3:0], lo_val[3:0]} == xor_q)
                && (fill_q >= CW'(MIN_FILL));
  end

  // Next state.
  always_comb begin
    phase_d    = phase_q;
    fill_d     = fill_q;
    xor_d      = xor_q;
    digit_hi_d = digit_hi_q;
    remain_d   = remain_q;
    if (in_fire && !is_nul) begin
      if (is_dollar) begin
        fill_d  = CW'(1);
        xor_d   = '0;
        phase_d = PH_PAYLOAD;
      end else if (is_bad) begin
        fill_d  = '0;
        phase_d = PH_WAIT_START;
      end else if (is_star) begin
        if (phase_q == PH_PAYLOAD) begin
          fill_d  = fill_q + CW'(1);
          phase_d = PH_DIGIT1;
        end else begin
          fill_d  = '0;
          phase_d = PH_WAIT_START;
        end
      end else begin
        unique case (phase_q)
          PH_WAIT_START: begin
          end
          PH_PAYLOAD: begin
            fill_d = fill_q + CW'(1);
            xor_d  = xor_q ^ rx_byte_i;
          end
          PH_DIGIT1: begin
            fill_d     = fill_q + CW'(1);
            digit_hi_d = rx_byte_i;
            phase_d    = PH_DIGIT2;
          end
          PH_DIGIT2: begin
            if (sum_ok) begin
              remain_d = fill_q + CW'(1);
            end
            fill_d  = '0;
            phase_d = PH_WAIT_START;
          end
          default: begin
          end
        endcase
      end
    end else if (out_fire) begin
      remain_d = remain_q - CW'(1);
    end
  end

  // Outputs toward the cell row and the result channel.
  always_comb begin
    cell_ctrl_o.data  = rx_byte_i;
    cell_ctrl_o.shift = out_fire;
    cell_ctrl_o.load  = 1'b0;
    wr_idx_o          = is_dollar ? '0 : fill_q[IW-1:0];
    if (in_fire && !is_nul) begin
      if (is_dollar) begin
        cell_ctrl_o.load = 1'b1;
      end else if (!is_bad) begin
        if (is_star) begin
          cell_ctrl_o.load = (phase_q == PH_PAYLOAD);
        end else begin
          cell_ctrl_o.load = (phase_q != PH_WAIT_START);
        end
      end
    end
    last_of_line_o = (remain_q == CW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_WAIT_START;
      fill_q   <= '0;
      remain_q <= '0;
      xor_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      fill_q   <= fill_d;
      remain_q <= remain_d;
      xor_q    <= xor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_hi_q <= digit_hi_d;
  end

endmodule

>>> rtl/nmea_sentence_framer_core.sv
// ----------------------------------------------------------------------------
// nmea_sentence_framer_core
// Frames dollar-started sentences and forwards those with a good checksum.
// ----------------------------------------------------------------------------
// Usage: received characters enter one word at a time on the in channel
// (in_valid_i / in_ready_o, payload rx_byte_i). When the second checksum
// digit completes a sentence whose XOR matches and that holds at least one
// payload byte, the whole sentence, dollar through second digit, leaves on
// the out channel (out_valid_o / out_ready_i) one word per cycle while
// out_ready_i is high, with last_of_line_o on the final word.
// The first word of a sentence is offered in the cycle after the closing
// digit is accepted. The row of storage cells shifts one place toward the
// head per word delivered, and in_ready_o stays low until the last word is
// taken. A stalled receiver simply holds the row, so no word is lost.
// Throughput is one input word per cycle outside of these drain phases.
// Reset clears the framer to wait for a dollar and sets max_line_length to
// 64; buffer contents are not cleared, they are always written before use.
// max_line_length is written through the APB port at address 0.
module nmea_sentence_framer_core #(
  parameter int unsigned LINE_BUFFER_DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [nsf_pkg::BYTE_W-1:0]    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [nsf_pkg::BYTE_W-1:0]    line_byte_o,
  output logic                          last_of_line_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nsf_pkg::PADDR_W-1:0]   paddr,
  input  logic [nsf_pkg::APB_W-1:0]     pwdata,
  output logic [nsf_pkg::APB_W-1:0]     prdata,
  output logic                          pready
);
  import nsf_pkg::*;

  localparam int unsigned IW = $clog2(LINE_BUFFER_DEPTH);

  logic [CFG_W-1:0]  max_line_length_q;
  logic              cfg_write;
  cell_ctrl_t        cell_ctrl;
  logic [IW-1:0]     wr_idx;
  logic [BYTE_W-1:0] cell_data [LINE_BUFFER_DEPTH];

  // Configuration port. Writes complete in the access phase, no wait states.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == REG_MAX_LINE_ADDR);
  assign prdata    = (paddr == REG_MAX_LINE_ADDR) ?
                     {{(APB_W - CFG_W){1'b0}}, max_line_length_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_line_length_q <= MAX_LINE_RESET;
    end else if (cfg_write) begin
      max_line_length_q <= pwdata[CFG_W-1:0];
    end
  end

  nsf_ctrl #(
    .LINE_BUFFER_DEPTH (LINE_BUFFER_DEPTH)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .rx_byte_i         (rx_byte_i),
    .max_line_length_i (max_line_length_q),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .last_of_line_o    (last_of_line_o),
    .cell_ctrl_o       (cell_ctrl),
    .wr_idx_o          (wr_idx)
  );

  // The line buffer is a row of cells. Each byte is loaded at its position;
  // during delivery every cell takes its upper neighbor's byte, so the head
  // cell always holds the next word to send.
  for (genvar i = 0; i < LINE_BUFFER_DEPTH; i++) begin : g_cell
    logic [BYTE_W-1:0] next_data;
    if (i == LINE_BUFFER_DEPTH - 1) begin : g_tail
      assign next_data = '0;
    end else begin : g_body
      assign next_data = cell_data[i + 1];
    end
    nsf_cell #(
      .IDX_W    (IW),
      .CELL_IDX (i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl),
      .wr_idx_i    (wr_idx),
      .next_data_i (next_data),
      .data_o      (cell_data[i])
    );
  end

  assign line_byte_o = cell_data[0];

`ifndef SYNTH
  // While a sentence drains, no new character may enter.
  a_no_input_during_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input accepted while a sentence is being delivered");

  // Delivering the final word ends the sentence.
  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_of_line_o) |=> !out_valid_o)
    else $error("output still valid after the final word of a sentence");

  // A zero character never starts a delivery.
  a_nul_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (rx_byte_i == CHAR_NUL)) |=> !out_valid_o)
    else $error("zero character caused output");

  // The last flag only appears on a valid word.
  a_last_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_of_line_o |-> out_valid_o)
    else $error("last flag raised without a valid word");
`endif

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sentence framer: it streams received bytes,
// predicts the forwarded sentences and checks them word by word.
// ----------------------------------------------------------------------------
// Stimulus comes in three parts. A short opening list covers these cases:
// - a good line
// - a zero byte and a star outside a sentence
// - an empty payload
// - a dollar restart and a high byte with lowercase digits
// - a DEL in the payload
// - a bad digit
// Random traffic then runs under several line limits: the reset value, the
// out-of-range top value, the smallest limit that still passes a line, zero,
// one and a random value. Most of that traffic is well-formed sentences with
// random payload, length and checksum flavor. The rest is broken sentences
// and raw noise. Random gaps on the input side and random stalls on the
// output side are switched on and off per sentence. The last part runs
// without any of them.
// ----------------------------------------------------------------------------
module tb_top;
  import nsf_pkg::*;

  localparam int unsigned LINE_DEPTH = 64;

  // One expected word of a forwarded sentence.
  typedef struct {
    logic [BYTE_W-1:0] line_byte;
    logic              last_of_line;
  } line_word_t;

  // Mirrors the framer state and keeps the sentence words that are still due.
  class sentence_checker;
    logic [BYTE_W-1:0] frame_buf [LINE_DEPTH];
    int unsigned       held;
    framer_phase_e     phase;
    logic [BYTE_W-1:0] payload_xor;
    logic [CFG_W-1:0]  line_limit;
    line_word_t        due_line_words [$];
    int unsigned       faults;
    int unsigned       rx_words;
    int unsigned       live_words;
    int unsigned       words_checked;
    int unsigned       lines_passed;

    function new();
      held = 0;
      phase = PH_WAIT_START;
      payload_xor = '0;
      line_limit = MAX_LINE_RESET;
      faults = 0;
      rx_words = 0;
      live_words = 0;
      words_checked = 0;
      lines_passed = 0;
    endfunction

    function void set_line_limit(logic [CFG_W-1:0] v);
      line_limit = v;
    endfunction

    // Value of a hex digit in bits 3:0, bit 4 set when the byte is no digit.
    function logic [4:0] digit_of(logic [BYTE_W-1:0] c);
      if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
      if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
        return {1'b0, 4'(c[3:0] + 4'd9)};
      end
      return 5'h10;
    endfunction

    function void restart();
      held = 0;
      phase = PH_WAIT_START;
    endfunction

    function void keep(logic [BYTE_W-1:0] c);
      if (held < LINE_DEPTH) begin
        frame_buf[held] = c;
        held++;
      end
    endfunction

    // Called for every accepted rx word; queues the sentence when one passes.
    function void take_rx_byte(logic [BYTE_W-1:0] c);
      int unsigned cap;
      int unsigned k;
      logic [4:0]  hi;
      logic [4:0]  lo;
      line_word_t  w;
      rx_words++;
      if (c != CHAR_NUL && (phase != PH_WAIT_START || c == CHAR_DOLLAR)) begin
        live_words++;
      end
      cap = (line_limit > LINE_DEPTH) ? LINE_DEPTH : line_limit;
      if (c == CHAR_NUL) return;
      if (c == CHAR_DOLLAR) begin
        frame_buf[0] = c;
        held = 1;
        payload_xor = '0;
        phase = PH_PAYLOAD;
        return;
      end
      if (held >= cap || c <= CHAR_SPACE || c == CHAR_DEL) begin
        restart();
        return;
      end
      if (c == CHAR_STAR) begin
        if (phase == PH_PAYLOAD) begin
          keep(c);
          phase = PH_DIGIT1;
        end else begin
          restart();
        end
        return;
      end
      case (phase)
        PH_PAYLOAD: begin
          keep(c);
          payload_xor ^= c;
        end
        PH_DIGIT1: begin
          keep(c);
          phase = PH_DIGIT2;
        end
        PH_DIGIT2: begin
          keep(c);
          if (held > MIN_FILL) begin
            hi = digit_of(frame_buf[held-2]);
            lo = digit_of(frame_buf[held-1]);
            if (!hi[4] && !lo[4] && {hi[3:0], lo[3:0]} == payload_xor) begin
              for (k = 0; k < held; k++) begin
                w.line_byte = frame_buf[k];
                w.last_of_line = (k + 1 == held);
                due_line_words.push_back(w);
              end
            end
          end
          restart();
        end
        default: ;
      endcase
    endfunction

    function void check_line_byte(logic [BYTE_W-1:0] b, logic last);
      line_word_t w;
      words_checked++;
      if (due_line_words.size() == 0) begin
        $display("%0t: unexpected line word: expected none, actual byte %02h last %0b",
                 $time, b, last);
        faults++;
        return;
      end
      w = due_line_words.pop_front();
      if (b !== w.line_byte) begin
        $display("%0t: line_byte mismatch: expected %02h, actual %02h",
                 $time, w.line_byte, b);
        faults++;
      end
      if (last !== w.last_of_line) begin
        $display("%0t: last_of_line mismatch: expected %0b, actual %0b",
                 $time, w.last_of_line, last);
        faults++;
      end
      if (w.last_of_line) lines_passed++;
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [BYTE_W-1:0]   rx_byte_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [BYTE_W-1:0]   line_byte_o;
  logic                last_of_line_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [APB_W-1:0]    pwdata;
  logic [APB_W-1:0]    prdata;
  logic                pready;

  sentence_checker lines = new();

  // Random idling on both sides is allowed while this is set.
  bit idle_on;
  // The sender raises this to ask the receiver for one long hold-off.
  bit hold_req;

  nmea_sentence_framer_core #(
    .LINE_BUFFER_DEPTH(LINE_DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .line_byte_o    (line_byte_o),
    .last_of_line_o (last_of_line_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: checks every delivered word, then picks the next ready value.
  // A hold-off request from the sender keeps ready low for a long counted
  // stretch so that the block backs up and stalls its input.
  initial begin : receiver
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_done;
    stall_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
        lines.check_line_byte(line_byte_o, last_of_line_o);
      end
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 10) return 8'(8'h30 + n);
    return 8'((lower ? 8'h61 : 8'h41) + n - 10);
  endfunction

  // Printable or high byte that neither starts nor ends a payload.
  function automatic logic [BYTE_W-1:0] payload_char();
    logic [BYTE_W-1:0] b;
    do begin
      if ($urandom_range(0, 5) == 0) b = 8'($urandom_range(128, 255));
      else b = 8'($urandom_range(33, 126));
    end while (b == CHAR_DOLLAR || b == CHAR_STAR);
    return b;
  endfunction

  // Offers one word and returns at the edge that accepts it. Called at an edge.
  task automatic send_word(input logic [BYTE_W-1:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    lines.take_rx_byte(b);
  endtask

  // Drops valid and waits until every due word is out, plus the latency of
  // a closing digit that turned out to carry no sentence.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (lines.due_line_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes max_line_length through APB, then reads it back.
  task automatic write_line_limit(input logic [CFG_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_MAX_LINE_ADDR;
    pwdata <= APB_W'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    lines.set_line_limit(v);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    if (prdata !== APB_W'(v)) begin
      $display("%0t: max_line_length readback mismatch: expected %0d, actual %0d",
               $time, v, prdata);
      lines.faults++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // A sentence with random payload. Most carry a good checksum. Some have
  // one flipped checksum bit, and some have a non-hex low digit.
  task automatic send_random_sentence(input int unsigned plen);
    logic [BYTE_W-1:0] check_xor;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] digit_lo;
    logic [4:0]        dv;
    int unsigned       k;
    int unsigned       flavor;
    check_xor = '0;
    send_word(CHAR_DOLLAR);
    for (k = 0; k < plen; k++) begin
      b = payload_char();
      check_xor ^= b;
      if ($urandom_range(0, 19) == 0) send_word(CHAR_NUL);
      send_word(b);
    end
    send_word(CHAR_STAR);
    flavor = $urandom_range(0, 9);
    if (flavor == 0) check_xor ^= 8'(1 << $urandom_range(0, 7));
    digit_lo = hex_char(check_xor[3:0], $urandom_range(0, 1));
    if (flavor == 1) begin
      do begin
        digit_lo = 8'($urandom_range(33, 255));
        dv = lines.digit_of(digit_lo);
      end while (!dv[4] || digit_lo == CHAR_DOLLAR || digit_lo == CHAR_STAR ||
                 digit_lo == CHAR_DEL);
    end
    send_word(hex_char(check_xor[7:4], $urandom_range(0, 1)));
    send_word(digit_lo);
  endtask

  // Random traffic until the given number of words has been accepted.
  task automatic run_mix(input int unsigned target, input bit with_idle);
    int unsigned start;
    int unsigned pick;
    int unsigned k;
    int unsigned plen;
    start = lines.rx_words;
    while (lines.rx_words - start < target) begin
      if (with_idle) idle_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        if ($urandom_range(0, 11) == 0) plen = $urandom_range(56, 61);
        else plen = $urandom_range(0, 8);
        send_random_sentence(plen);
      end else if (pick < 9) begin
        // Broken sentence: cut by a control byte, space, DEL, a second star or a random byte.
        send_word(CHAR_DOLLAR);
        repeat ($urandom_range(0, 5)) send_word(payload_char());
        case ($urandom_range(0, 3))
          0: send_word(8'($urandom_range(1, 32)));
          1: send_word(CHAR_DEL);
          2: begin
            send_word(CHAR_STAR);
            send_word(CHAR_STAR);
          end
          default: send_word(8'($urandom_range(0, 255)));
        endcase
      end else begin
        for (k = $urandom_range(1, 5); k > 0; k--) send_word(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin : stimulus
    logic [BYTE_W-1:0] opening [$];
    idle_on = 1'b0;
    hold_req = 1'b0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    rx_byte_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_line_limit(MAX_LINE_RESET);

    // Opening cases, in order: a good line, a zero byte, a star outside a
    // sentence, an empty payload, a restart followed by a high payload byte
    // with lowercase digits, a DEL inside the payload, a bad low digit.
    opening = '{CHAR_DOLLAR, "A", CHAR_STAR, "4", "1",
                CHAR_NUL,
                CHAR_STAR,
                CHAR_DOLLAR, CHAR_STAR, "0", "0",
                CHAR_DOLLAR, "Z", CHAR_DOLLAR, 8'hFF, CHAR_STAR, "f", "f",
                CHAR_DOLLAR, "b", CHAR_DEL,
                CHAR_DOLLAR, "c", CHAR_STAR, "6", "G"};
    foreach (opening[i]) send_word(opening[i]);
    settle();

    // Reset limit with idling. Midway the receiver holds off for a long
    // stretch while the sender keeps offering full sentences at full rate.
    run_mix(20, 1'b1);
    idle_on = 1'b0;
    hold_req = 1'b1;
    repeat (3) send_random_sentence(12);
    run_mix(5, 1'b1);
    // The sender waits here until every due word is out.
    settle();
    run_mix(10, 1'b1);
    settle();

    // A limit above the buffer depth acts as the depth.
    write_line_limit(7'd127);
    run_mix(10, 1'b1);
    settle();

    // Five is the smallest limit under which a one-byte payload passes.
    write_line_limit(7'd5);
    run_mix(10, 1'b1);
    settle();

    // Zero and one let nothing through.
    write_line_limit(7'd0);
    run_mix(6, 1'b1);
    settle();
    write_line_limit(7'd1);
    run_mix(6, 1'b1);
    settle();

    write_line_limit(7'($urandom_range(6, 63)));
    run_mix(10, 1'b1);
    settle();

    // Closing part at full rate with no idling at all.
    write_line_limit(MAX_LINE_RESET);
    idle_on = 1'b0;
    run_mix(15, 1'b0);
    settle();

    $display("Framer took %0d words, %0d inside a sentence, under line limits %s",
             lines.rx_words, lines.live_words, "0, 1, 5, 64, 127 and one random.");
    $display("%0d sentences came through, %0d words checked, %0d faults.",
             lines.lines_passed, lines.words_checked, lines.faults);
    if (lines.faults == 0 && lines.due_line_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> nmea_sentence_framer_core.f
rtl/nsf_pkg.sv
rtl/nsf_cell.sv
rtl/nsf_ctrl.sv
rtl/nmea_sentence_framer_core.sv
bench/tb_top.sv
